// ===== sv/a2d_pkg.sv =====
package a2d_pkg;

    // Input width used for the coordinates and fraction bits of the ratio
    localparam int IN_WIDTH  = 32;
    localparam int FRAC_BITS = 16;

    // Fixed port widths
    localparam int COORD_W = 32;
    localparam int ANG_W   = 12;

    // Ratio t, unsigned magnitude in Q1.FRAC_BITS
    localparam int T_W = FRAC_BITS + 1;

    // Approximation constants
    localparam int K_SCALE_W = 10;
    localparam int K_Q028_W  = 15;
    localparam logic [K_SCALE_W-1:0] K_SCALE = K_SCALE_W'(573);
    localparam logic [K_Q028_W-1:0]  K_Q028  = K_Q028_W'(18350);
    localparam int K_Q028_SHIFT = 16;
    localparam int K_QUARTER    = 900;
    localparam int K_HALF       = 1800;

    // Term unit widths
    localparam int SQ_W   = 2 * FRAC_BITS + 1;
    localparam int PROD_W = K_Q028_W + SQ_W;
    localparam int DEN_W  = 2 * FRAC_BITS + 1;
    localparam int Q_W    = 10;
    localparam int NUM_W  = K_SCALE_W + T_W + FRAC_BITS;

    // Pipeline depths
    localparam int DIV1_LAT = T_W;
    localparam int TERM_LAT = 2 + Q_W;
    localparam int FLG_LAT  = DIV1_LAT + TERM_LAT;
    localparam int TOT_LAT  = 2 + FLG_LAT;

    // Per-item quadrant information carried alongside the datapath
    typedef struct packed {
        logic zero;
        logic swap;
        logic yn;
        logic xn;
    } t_flags;

endpackage

// ===== sv/a2d_term.sv =====
// Term magnitude 573*t/(1+0.28*t^2): two multiply stages, then a
// restoring divider with one quotient bit per stage.
module a2d_term
    import a2d_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [T_W-1:0] i_tm,
    output logic           o_valid,
    output logic [Q_W-1:0] o_q,
    output logic           o_inexact
);

    // Multiply stage a: square of t
    logic           r_va;
    logic [T_W-1:0] r_tm_a;
    logic [SQ_W-1:0] r_sq;

    // Multiply stage b: divider operands
    logic             r_vb;
    logic [DEN_W-1:0] r_den_b;
    logic [NUM_W-1:0] r_num_b;

    // Divider stages
    logic [Q_W-1:0]   r_vd;
    logic [NUM_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_dd  [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];
    logic [NUM_W-1:0] n_rem [Q_W];
    logic [Q_W-1:0]   n_q   [Q_W];

    logic [PROD_W-1:0] w_prod;

    assign w_prod = (PROD_W'(K_Q028) * PROD_W'(r_sq)) >> K_Q028_SHIFT;

    always_ff @(posedge i_clk) begin
        r_tm_a  <= i_tm;
        r_sq    <= SQ_W'(i_tm * i_tm);
        r_den_b <= DEN_W'({1'b1, {(2 * FRAC_BITS){1'b0}}}) + DEN_W'(w_prod);
        r_num_b <= NUM_W'(NUM_W'(K_SCALE) * NUM_W'(r_tm_a)) << FRAC_BITS;
    end

    // One compare-subtract per stage, bit Q_W-1-j at stage j
    always_comb begin
        logic [NUM_W-1:0] rin;
        logic [NUM_W-1:0] sd;
        logic [Q_W-1:0]   qin;
        logic             ge;
        for (int j = 0; j < Q_W; j++) begin
            rin = (j == 0) ? r_num_b : r_rem[j-1];
            qin = (j == 0) ? '0 : r_q[j-1];
            sd  = NUM_W'((j == 0) ? r_den_b : r_dd[j-1]) << (Q_W - 1 - j);
            ge  = (rin >= sd);
            n_rem[j] = ge ? (rin - sd) : rin;
            n_q[j]   = {qin[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < Q_W; j++) begin
            r_rem[j] <= n_rem[j];
            r_q[j]   <= n_q[j];
            r_dd[j]  <= (j == 0) ? r_den_b : r_dd[j-1];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vd <= '0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vd <= {r_vd[Q_W-2:0], r_vb};
        end
    end

    assign o_valid   = r_vd[Q_W-1];
    assign o_q       = r_q[Q_W-1];
    assign o_inexact = (r_rem[Q_W-1] != '0);

    // Term never exceeds 573/1.28
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_q <= Q_W'(448)))
        else $error("term magnitude out of range");

endmodule

// ===== sv/atan2_decidegree_approximation.sv =====
// Channel   | Ports                           | Transfer
// ----------+---------------------------------+-------------------------------
// command   | i_start, o_busy, i_y/x_coord    | edge with i_start & !o_busy
// result    | o_strobe, o_angle_decideg       | each strobed cycle, one item
//
// One item per cycle; each result passes through the input stage, the 17-stage
// ratio divider, the term unit and the output register after its transfer.
// Synchronous active-low reset clears all valid bits; o_busy is high only
// during reset. The receiver cannot stall, so the pipeline never holds.
module atan2_decidegree_approximation
    import a2d_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic signed [COORD_W-1:0] i_x_coord,
    output logic                     o_strobe,
    output logic signed [ANG_W-1:0]  o_angle_decideg
);

    localparam int REM_W = IN_WIDTH + 1;

    assign o_busy = ~i_rst_n;

    // Stage 0: sign/magnitude split, operand ordering
    logic [IN_WIDTH-1:0] w_yv, w_xv, w_ay, w_ax;
    logic                w_yn, w_xn;

    assign w_yv = i_y_coord[IN_WIDTH-1:0];
    assign w_xv = i_x_coord[IN_WIDTH-1:0];
    assign w_yn = w_yv[IN_WIDTH-1];
    assign w_xn = w_xv[IN_WIDTH-1];
    assign w_ay = w_yn ? (~w_yv + 1'b1) : w_yv;
    assign w_ax = w_xn ? (~w_xv + 1'b1) : w_xv;

    logic                r_v0;
    logic [IN_WIDTH-1:0] r_num, r_den;
    t_flags              r_f0;

    // Origin uses a unit divisor so t is zero and the term stays in range
    always_ff @(posedge i_clk) begin
        r_f0.zero <= (w_ay == '0) && (w_ax == '0);
        r_f0.swap <= !(w_ay < w_ax);
        r_f0.yn   <= w_yn;
        r_f0.xn   <= w_xn;
        r_num     <= (w_ay < w_ax) ? w_ay : w_ax;
        r_den     <= (w_ay < w_ax) ? w_ax : ((w_ay == '0) ? IN_WIDTH'(1) : w_ay);
    end

    // Ratio divider: one quotient bit of t per stage
    logic [DIV1_LAT-1:0] r_vd;
    logic [REM_W-1:0]    r_rem [DIV1_LAT];
    logic [IN_WIDTH-1:0] r_dd  [DIV1_LAT];
    logic [T_W-1:0]      r_q   [DIV1_LAT];
    logic [REM_W-1:0]    n_rem [DIV1_LAT];
    logic [T_W-1:0]      n_q   [DIV1_LAT];

    always_comb begin
        logic [REM_W-1:0]    rin;
        logic [REM_W-1:0]    dif;
        logic [IN_WIDTH-1:0] din;
        logic [T_W-1:0]      qin;
        logic                ge;
        for (int k = 0; k < DIV1_LAT; k++) begin
            rin = (k == 0) ? {1'b0, r_num} : r_rem[k-1];
            din = (k == 0) ? r_den : r_dd[k-1];
            qin = (k == 0) ? '0 : r_q[k-1];
            ge  = (rin >= {1'b0, din});
            dif = ge ? (rin - {1'b0, din}) : rin;
            n_rem[k] = {dif[IN_WIDTH-1:0], 1'b0};
            n_q[k]   = {qin[T_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV1_LAT; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
            r_dd[k]  <= (k == 0) ? r_den : r_dd[k-1];
        end
    end

    // Flags travel with the item through both dividers
    t_flags r_fd [FLG_LAT];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FLG_LAT; i++) begin
            r_fd[i] <= (i == 0) ? r_f0 : r_fd[i-1];
        end
    end

    // Term unit
    logic           w_tv, w_inex;
    logic [Q_W-1:0] w_q;

    a2d_term u_term (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_vd[DIV1_LAT-1]),
        .i_tm      (r_q[DIV1_LAT-1]),
        .o_valid   (w_tv),
        .o_q       (w_q),
        .o_inexact (w_inex)
    );

    // Quadrant fixup
    localparam int A_W = ANG_W + 1;
    t_flags                w_f;
    logic signed [A_W-1:0] w_t, n_ang;

    assign w_f = r_fd[FLG_LAT-1];
    assign w_t = signed'(A_W'(w_q));

    always_comb begin
        if (w_f.zero) begin
            n_ang = '0;
        end else if (!w_f.swap) begin
            n_ang = (w_f.yn != w_f.xn) ? -w_t : w_t;
            if (w_f.xn) begin
                n_ang = w_f.yn ? (n_ang - A_W'(K_HALF)) : (n_ang + A_W'(K_HALF));
            end
        end else begin
            if (w_f.yn != w_f.xn) begin
                n_ang = A_W'(K_QUARTER) + w_t;
            end else begin
                n_ang = A_W'(K_QUARTER) - w_t - A_W'(w_inex);
            end
            if (w_f.yn) begin
                n_ang = n_ang - A_W'(K_HALF);
            end
        end
    end

    logic                    r_str;
    logic signed [ANG_W-1:0] r_ang;

    always_ff @(posedge i_clk) begin
        r_ang <= n_ang[ANG_W-1:0];
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_vd  <= '0;
            r_str <= 1'b0;
        end else begin
            r_v0  <= i_start;
            r_vd  <= {r_vd[DIV1_LAT-2:0], r_v0};
            r_str <= w_tv;
        end
    end

    assign o_strobe        = r_str;
    assign o_angle_decideg = r_ang;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, TOT_LAT))
        else $error("result without matching transfer");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_angle_decideg <= ANG_W'(K_HALF)
                      && o_angle_decideg >= -ANG_W'(K_HALF)))
        else $error("angle out of range");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tv && w_f.zero) |=> (o_angle_decideg == '0))
        else $error("origin must give zero");

endmodule

// ===== test/atan2_decidegree_checker.sv =====
module atan2_decidegree_checker
    import a2d_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic                      i_strobe,
    input  logic signed [ANG_W-1:0]   i_angle_decideg,
    output int                        o_errors,
    output int                        o_pending
);

    // Angles expected, oldest first
    logic signed [ANG_W-1:0] angle_q[$];
    int                      err_count = 0;

    // Magnitude of 0.28-weighted rational term for ratio magnitude t
    function automatic logic [63:0] rational_term(input logic [63:0] t, output logic rem);
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] q;
        den = (64'd1 << (2 * FRAC_BITS)) + ((64'd18350 * t * t) >> 16);
        num = (64'd573 * t) << FRAC_BITS;
        q   = num / den;
        rem = (num - q * den) != 0;
        return q;
    endfunction

    // Expected angle in tenths of a degree
    function automatic logic signed [ANG_W-1:0] predict_angle(
        input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] x);
        logic                yn, xn, rem;
        logic [IN_WIDTH-1:0] yv, xv;
        logic [63:0]         ay, ax, t, q;
        int                  a;
        yv = y[IN_WIDTH-1:0];
        xv = x[IN_WIDTH-1:0];
        yn = yv[IN_WIDTH-1];
        xn = xv[IN_WIDTH-1];
        if (yn) yv = ~yv + 1'b1;
        if (xn) xv = ~xv + 1'b1;
        ay = 64'(yv);
        ax = 64'(xv);
        if (ay == 0 && ax == 0) begin
            a = 0;
        end else if (ay < ax) begin
            t = (ay << FRAC_BITS) / ax;
            q = rational_term(t, rem);
            a = (yn != xn) ? -int'(q) : int'(q);
            if (xn) a += yn ? -K_HALF : K_HALF;
        end else begin
            t = (ax << FRAC_BITS) / ay;
            q = rational_term(t, rem);
            if (yn != xn) a = K_QUARTER + int'(q);
            else          a = K_QUARTER - int'(q) - (rem ? 1 : 0);
            if (yn) a -= K_HALF;
        end
        return a[ANG_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    assign o_errors = err_count;

    // Record each command transfer, check each strobed result
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !i_busy)
            angle_q.push_back(predict_angle(i_y_coord, i_x_coord));
        if (i_rst_n && i_strobe) begin
            if (angle_q.size() == 0) begin
                report_mismatch($sformatf("unexpected angle %0d", i_angle_decideg));
            end else begin
                if (angle_q[0] !== i_angle_decideg)
                    report_mismatch($sformatf("angle %0d, want %0d",
                        i_angle_decideg, angle_q[0]));
                void'(angle_q.pop_front());
            end
        end
        o_pending = angle_q.size();
    end

endmodule

// ===== test/tb_atan2_decidegree_approximation.sv =====
module tb_atan2_decidegree_approximation;
    import a2d_pkg::*;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic signed [COORD_W-1:0] i_y_coord;
    logic signed [COORD_W-1:0] i_x_coord;
    logic                      o_strobe;
    logic signed [ANG_W-1:0]   o_angle_decideg;
    int                        errors;
    int                        pending;

    localparam logic signed [31:0] CMAX = 32'h7fff_ffff;
    localparam logic signed [31:0] CMIN = 32'h8000_0000;

    atan2_decidegree_approximation dut (.*);

    atan2_decidegree_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_y_coord(i_y_coord), .i_x_coord(i_x_coord), .i_strobe(o_strobe),
        .i_angle_decideg(o_angle_decideg), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Present one coordinate pair and hold it until transferred
    task automatic send_pair(input logic [31:0] y, input logic [31:0] x);
        @(negedge i_clk);
        i_start   = 1;
        i_y_coord = y;
        i_x_coord = x;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
    endtask

    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        i_start = 0;
        repeat (n) @(negedge i_clk);
    endtask

    // Random pair: full range, small, near-equal magnitudes, a zero or most-negative coordinate, or y derived from x
    task automatic send_random;
        logic [31:0] y, x;
        int          m;
        m = $urandom_range(0, 9);
        y = $urandom;
        x = $urandom;
        case (m)
            0, 1, 2: ;
            3, 4: begin
                y = 32'($signed(y) >>> $urandom_range(0, 31));
                x = 32'($signed(x) >>> $urandom_range(0, 31));
            end
            5, 6: begin
                x = $urandom_range(0, 1) ? y : -y;
                x = x + $urandom_range(0, 2) - 1;
            end
            7: y = $urandom_range(0, 1) ? 0 : CMIN;
            8: x = $urandom_range(0, 1) ? 0 : CMIN;
            default: y = 32'($signed(x) >>> $urandom_range(0, 8)) ^ $urandom_range(0, 255);
        endcase
        send_pair(y, x);
    endtask

    initial begin
        int sent;
        i_rst_n   = 0;
        i_start   = 0;
        i_y_coord = 0;
        i_x_coord = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Origin, axes, equal magnitudes, extremes, small and large ratios
        send_pair(0, 0);       send_pair(0, -5);      send_pair(0, 5);
        send_pair(5, 0);       send_pair(-5, 0);      send_pair(CMAX, CMAX);
        send_pair(CMIN, CMIN); send_pair(CMIN, CMAX); send_pair(CMAX, CMIN);
        send_pair(-1, 1);      send_pair(1, -1);      send_pair(3, 3);
        send_pair(-3, -3);     send_pair(3, -3);      send_pair(-3, 3);
        send_pair(7, 100);     send_pair(-7, 100);    send_pair(7, -100);
        send_pair(-7, -100);   send_pair(100, 7);     send_pair(-100, -7);
        send_pair(CMIN, 0);    send_pair(0, CMIN);    send_pair(1, CMIN);
        idle_cycles(3);

        // Bursts with random gaps, some back to back
        sent = 0;
        while (sent < 1550) begin
            repeat ($urandom_range(1, 40)) begin
                send_random();
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(0, 6));
        end
        idle_cycles(0);

        while (pending != 0) @(posedge i_clk);
        repeat (TOT_LAT + 10) @(posedge i_clk);
        if (errors == 0)
            $display("[atan2_decidegree_approximation] OK");
        else
            $display("[atan2_decidegree_approximation] ERROR");
        $finish;
    end

    initial begin
        #500000;
        $display("[atan2_decidegree_approximation] ERROR");
        $finish;
    end

endmodule
